// ===== design/depq_pkg.sv =====
// ----------------------------------------------------------------------------
// depq_pkg
// Shared types and constants for the double-ended priority queue.
// ----------------------------------------------------------------------------
package depq_pkg;

    localparam int KEY_W   = 32;
    localparam int CMD_W   = 2;
    localparam int COUNT_W = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT  = 2'd0,
        CMD_DEL_MAX = 2'd1,
        CMD_DEL_MIN = 2'd2,
        CMD_NOP     = 2'd3
    } t_cmd;

    // Broadcast to every cell in the chain
    typedef struct packed {
        logic                    ins;
        logic                    del_max;
        logic                    del_min;
        logic signed [KEY_W-1:0] key;
    } t_cell_ctl;

    // What one cell shows to its neighbors and to the result stage
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic                    valid;
        logic                    place;  // new key belongs at or below this cell
        logic                    last;   // highest valid cell
    } t_cell_out;

endpackage

// ===== design/depq_cell.sv =====
// ----------------------------------------------------------------------------
// depq_cell
// One slot of the sorted key chain; shifts up on insert, down on delete-min.
// ----------------------------------------------------------------------------
module depq_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  depq_pkg::t_cell_ctl  i_ctl,
    input  depq_pkg::t_cell_out  i_prev,
    input  depq_pkg::t_cell_out  i_next,
    output depq_pkg::t_cell_out  o_cell
);
    import depq_pkg::*;

    logic signed [KEY_W-1:0] r_key;
    logic signed [KEY_W-1:0] n_key;
    logic                    r_valid;
    logic                    n_valid;
    logic                    w_place;
    logic                    w_last;

    // Equal keys stay below the new one
    assign w_place = !r_valid || (r_key > i_ctl.key);
    assign w_last  = r_valid && !i_next.valid;

    always_comb begin
        n_key   = r_key;
        n_valid = r_valid;
        priority if (i_ctl.ins) begin
            if (w_place) begin
                if (i_prev.place) begin
                    n_key   = i_prev.key;
                    n_valid = i_prev.valid;
                end else begin
                    n_key   = i_ctl.key;
                    n_valid = 1'b1;
                end
            end
        end else if (i_ctl.del_min) begin
            n_key   = i_next.key;
            n_valid = i_next.valid;
        end else if (i_ctl.del_max) begin
            if (w_last) begin
                n_valid = 1'b0;
            end
        end else begin
            // Hold the slot when no request arrives
            n_key   = r_key;
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_cell.key   = r_key;
    assign o_cell.valid = r_valid;
    assign o_cell.place = w_place;
    assign o_cell.last  = w_last;

endmodule

// ===== design/double_ended_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// Throughput: one request per cycle while the result channel does not stall;
//   every cell updates in the cycle it is accepted, and the result register
//   reads the chain once the pending request can move out.
// Input stall rises only while a finished result is held and the output stalls.
// Reset (synchronous, active low) empties the store; no clearing pass.
// ----------------------------------------------------------------------------
// double_ended_priority_queue_top
// Sorted chain of key cells with insert, delete-largest and delete-smallest.
// ----------------------------------------------------------------------------
module double_ended_priority_queue_top #(
    parameter int CAPACITY = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // request channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [depq_pkg::CMD_W-1:0]           i_command,
    input  logic signed [depq_pkg::KEY_W-1:0]    i_key_value,
    // result channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [depq_pkg::KEY_W-1:0]    o_largest_key,
    output logic signed [depq_pkg::KEY_W-1:0]    o_smallest_key,
    output logic                                 o_store_empty,
    output logic [depq_pkg::COUNT_W-1:0]         o_entry_count,
    output logic                                 o_insert_dropped
);
    import depq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    // ---------------------------------------------------------------- control
    t_cmd           w_cmd;
    logic           w_acc;
    logic           w_can_emit;
    logic           w_full;
    logic           w_drop;
    t_cell_ctl      w_ctl;

    logic [CW-1:0]  r_count;
    logic [CW-1:0]  n_count;
    logic           r_pend;
    logic           r_pend_drop;

    assign w_cmd      = t_cmd'(i_command);
    assign w_full     = (r_count == CW'(CAPACITY));
    // The result register is free, or its content leaves at this edge
    assign w_can_emit = !o_out_valid || !i_out_stall;
    assign o_in_stall = r_pend && !w_can_emit;
    assign w_acc      = i_in_valid && !o_in_stall;
    assign w_drop     = (w_cmd == CMD_INSERT) && w_full;

    // Broadcast the accepted request to every cell
    assign w_ctl.ins     = w_acc && (w_cmd == CMD_INSERT) && !w_full;
    assign w_ctl.del_max = w_acc && (w_cmd == CMD_DEL_MAX);
    assign w_ctl.del_min = w_acc && (w_cmd == CMD_DEL_MIN);
    assign w_ctl.key     = i_key_value;

    always_comb begin
        n_count = r_count;
        if (w_acc) begin
            unique case (w_cmd)
                CMD_INSERT: begin
                    if (!w_full) begin
                        n_count = r_count + 1'b1;
                    end
                end
                CMD_DEL_MAX, CMD_DEL_MIN: begin
                    // Ignore deletes on an empty store
                    if (r_count != '0) begin
                        n_count = r_count - 1'b1;
                    end
                end
                CMD_NOP: begin
                    n_count = r_count;
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------- cell chain
    t_cell_out w_cell [CAPACITY];
    t_cell_out w_edge;

    // Outside both ends: no key, never the insert place
    assign w_edge = '{key: '0, valid: 1'b0, place: 1'b0, last: 1'b0};

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_cell_out w_prev;
        t_cell_out w_next;
        if (g == 0) begin : g_lo
            assign w_prev = w_edge;
        end else begin : g_lo
            assign w_prev = w_cell[g-1];
        end
        if (g == CAPACITY - 1) begin : g_hi
            assign w_next = w_edge;
        end else begin : g_hi
            assign w_next = w_cell[g+1];
        end
        depq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .o_cell  (w_cell[g])
        );
    end

    // ---------------------------------------------------------------- result
    // The highest valid cell is one-hot, so an AND-OR picks the largest key;
    // nothing is selected when the store is empty, which yields zero.
    logic signed [KEY_W-1:0] w_largest;
    logic signed [KEY_W-1:0] w_smallest;

    always_comb begin
        w_largest = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_largest = w_largest | (w_cell[i].key & {KEY_W{w_cell[i].last}});
        end
    end

    assign w_smallest = w_cell[0].valid ? w_cell[0].key : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_pend_drop <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            // Hold a pending request until the result register takes it
            if (w_acc) begin
                r_pend      <= 1'b1;
                r_pend_drop <= w_drop;
            end else if (w_can_emit) begin
                r_pend <= 1'b0;
            end
            if (r_pend && w_can_emit) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // Result payload: load only when a pending request moves out
    always_ff @(posedge i_clk) begin
        if (r_pend && w_can_emit) begin
            o_largest_key    <= w_largest;
            o_smallest_key   <= w_smallest;
            o_store_empty    <= (r_count == '0);
            o_entry_count    <= COUNT_W'(r_count);
            o_insert_dropped <= r_pend_drop;
        end
    end

    // ---------------------------------------------------------------- checks
    // The lowest cell is valid exactly when the count is nonzero
    a_count_matches_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cell[0].valid == (r_count != '0))
        else $error("cell chain and count disagree");

    // A taken insert grows the count by one
    a_insert_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.ins |=> (r_count == CW'($past(r_count) + 1'b1)))
        else $error("insert did not advance count");

    // A refused insert means the store was full
    a_drop_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_drop) |-> (r_count == CW'(CAPACITY)))
        else $error("insert dropped with room left");

    // Reported extremes are ordered
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_store_empty) |-> (o_smallest_key <= o_largest_key))
        else $error("smallest key above largest key");

    // A pending result never gets overwritten by a new request
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && o_out_valid && i_out_stall) |-> o_in_stall)
        else $error("request accepted over a held result");

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the double-ended priority queue. A shadow copy of
// the key store predicts largest, smallest, empty, count and refused-insert
// for every request; results are matched in order against those predictions
// while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import depq_pkg::*;

    localparam int CAPACITY    = 64;
    localparam int RANDOM_REQS = 1800;
    localparam int BLOCK_LEN   = 150;

    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;

    // What the block shows after one request
    typedef struct {
        logic signed [KEY_W-1:0] largest;
        logic signed [KEY_W-1:0] smallest;
        logic                    empty;
        logic [COUNT_W-1:0]      count;
        logic                    dropped;
    } t_store_view;

    // Shadow key store: predicts the view after each request and checks
    // results in arrival order.
    class depq_shadow;
        logic signed [KEY_W-1:0] sorted_keys[$];
        t_store_view             pending_views[$];
        int                      mismatches;
        int                      n_requests;
        int                      n_refused;
        int                      n_empty_deletes;
        int                      n_nops;
        int                      peak_count;

        function void apply_request(t_cmd op, logic signed [KEY_W-1:0] key);
            t_store_view view;
            int          pos;
            view.dropped = 1'b0;
            n_requests++;
            case (op)
                CMD_INSERT: begin
                    if (sorted_keys.size() >= CAPACITY) begin
                        view.dropped = 1'b1;
                        n_refused++;
                    end else begin
                        // keep ascending order; a duplicate lands after its equals
                        pos = 0;
                        while (pos < sorted_keys.size() && sorted_keys[pos] <= key)
                            pos++;
                        sorted_keys.insert(pos, key);
                    end
                end
                CMD_DEL_MAX: begin
                    if (sorted_keys.size() == 0) n_empty_deletes++;
                    else sorted_keys.delete(sorted_keys.size() - 1);
                end
                CMD_DEL_MIN: begin
                    if (sorted_keys.size() == 0) n_empty_deletes++;
                    else void'(sorted_keys.pop_front());
                end
                default: n_nops++;
            endcase
            if (sorted_keys.size() == 0) begin
                view.largest  = '0;
                view.smallest = '0;
                view.empty    = 1'b1;
            end else begin
                view.largest  = sorted_keys[sorted_keys.size() - 1];
                view.smallest = sorted_keys[0];
                view.empty    = 1'b0;
            end
            view.count = COUNT_W'(sorted_keys.size());
            if (sorted_keys.size() > peak_count) peak_count = sorted_keys.size();
            pending_views.insert(pending_views.size(), view);
        endfunction

        function void check_result(t_store_view got);
            t_store_view exp;
            if (pending_views.size() == 0) begin
                $error("result arrived with no request outstanding");
                mismatches++;
                return;
            end
            exp = pending_views.pop_front();
            if (got.largest !== exp.largest) begin
                $error("largest_key: expected %0d, got %0d", exp.largest, got.largest);
                mismatches++;
            end
            if (got.smallest !== exp.smallest) begin
                $error("smallest_key: expected %0d, got %0d", exp.smallest, got.smallest);
                mismatches++;
            end
            if (got.empty !== exp.empty) begin
                $error("store_empty: expected %0b, got %0b", exp.empty, got.empty);
                mismatches++;
            end
            if (got.count !== exp.count) begin
                $error("entry_count: expected %0d, got %0d", exp.count, got.count);
                mismatches++;
            end
            if (got.dropped !== exp.dropped) begin
                $error("insert_dropped: expected %0b, got %0b", exp.dropped, got.dropped);
                mismatches++;
            end
        endfunction

        function int pending();
            return pending_views.size();
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic [CMD_W-1:0]         i_command;
    logic signed [KEY_W-1:0]  i_key_value;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic signed [KEY_W-1:0]  o_largest_key;
    logic signed [KEY_W-1:0]  o_smallest_key;
    logic                     o_store_empty;
    logic [COUNT_W-1:0]       o_entry_count;
    logic                     o_insert_dropped;

    depq_shadow shadow = new();
    bit         quiet;   // set during the stretch where neither side idles

    double_ended_priority_queue_top #(
        .CAPACITY(CAPACITY)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_command       (i_command),
        .i_key_value     (i_key_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_largest_key   (o_largest_key),
        .o_smallest_key  (o_smallest_key),
        .o_store_empty   (o_store_empty),
        .o_entry_count   (o_entry_count),
        .o_insert_dropped(o_insert_dropped)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Receiver: stall about 29% of cycles, never during reset or the quiet stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n || quiet)
            i_out_stall <= 1'b0;
        else
            i_out_stall <= ($urandom_range(99) < 29);
    end

    // Monitor: note accepted requests first; a result always belongs to an
    // earlier request, so the order within one edge is safe.
    always @(posedge i_clk) begin
        t_store_view got;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                shadow.apply_request(t_cmd'(i_command), i_key_value);
            if (o_out_valid && !i_out_stall) begin
                got.largest  = o_largest_key;
                got.smallest = o_smallest_key;
                got.empty    = o_store_empty;
                got.count    = o_entry_count;
                got.dropped  = o_insert_dropped;
                shadow.check_result(got);
            end
        end
    end

    // Drive one request; optionally idle first, then hold it until accepted.
    task automatic send_request(input t_cmd op, input logic signed [KEY_W-1:0] key);
        // idle each cycle with about 29% odds
        while (!quiet && $urandom_range(99) < 29) begin
            i_in_valid  <= 1'b0;
            // scramble the payload while idle; it must be ignored
            i_command   <= CMD_W'($urandom_range(3));
            i_key_value <= $urandom;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_command   <= op;
        i_key_value <= key;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Keys: many near-duplicates, some extremes, the rest full range.
    function automatic logic signed [KEY_W-1:0] pick_key();
        case ($urandom_range(7))
            0, 1:    return KEY_W'($signed($urandom_range(16)) - 8);
            2: begin
                case ($urandom_range(3))
                    0:       return KEY_MAX;
                    1:       return KEY_MIN;
                    2:       return '0;
                    default: return -1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // Pick an operation; insert_pct shapes the block toward fill or drain.
    function automatic t_cmd pick_op(int insert_pct);
        int roll;
        roll = $urandom_range(99);
        if (roll < 3)                return CMD_NOP;
        if (roll < 3 + insert_pct)   return CMD_INSERT;
        return $urandom_range(1) ? CMD_DEL_MAX : CMD_DEL_MIN;
    endfunction

    initial begin
        int insert_pct;
        int waited;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_command   <= CMD_NOP;
        i_key_value <= '0;
        i_out_stall <= 1'b0;
        quiet        = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: deletes and no-op on an empty store, key extremes,
        // duplicates, ignored payloads on deletes, drain back to empty.
        send_request(CMD_DEL_MAX, $urandom);
        send_request(CMD_DEL_MIN, $urandom);
        send_request(CMD_NOP,     $urandom);
        send_request(CMD_INSERT,  KEY_MAX);
        send_request(CMD_INSERT,  KEY_MIN);
        send_request(CMD_INSERT,  '0);
        send_request(CMD_INSERT,  -1);
        send_request(CMD_INSERT,  KEY_MAX);
        send_request(CMD_INSERT,  KEY_MIN);
        send_request(CMD_INSERT,  32'sh5555_5555);
        send_request(CMD_INSERT,  32'shAAAA_AAAA);
        send_request(CMD_NOP,     $urandom);
        send_request(CMD_DEL_MAX, $urandom);
        send_request(CMD_DEL_MIN, $urandom);
        send_request(CMD_DEL_MAX, $urandom);
        send_request(CMD_DEL_MIN, $urandom);
        send_request(CMD_DEL_MAX, $urandom);
        send_request(CMD_DEL_MIN, $urandom);
        send_request(CMD_DEL_MAX, $urandom);
        send_request(CMD_DEL_MIN, $urandom);
        send_request(CMD_DEL_MIN, $urandom);
        send_request(CMD_DEL_MAX, $urandom);

        // Random: rotate through fill (runs into full capacity and refused
        // inserts), balanced, drain (runs into empty deletes), balanced.
        for (int n = 0; n < RANDOM_REQS; n++) begin
            case ((n / BLOCK_LEN) % 4)
                0:       insert_pct = 85;
                2:       insert_pct = 15;
                default: insert_pct = 48;
            endcase
            quiet = (n >= 700 && n < 1000);
            send_request(pick_op(insert_pct), pick_key());
        end
        quiet = 1'b0;
        i_in_valid <= 1'b0;
        // let the monitor note the last accepted request
        @(posedge i_clk);

        // Drain outstanding results, bounded.
        waited = 0;
        while (shadow.pending() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        if (shadow.pending() != 0) begin
            $display("double_ended_priority_queue_top test failed");
            $finish;
        end else begin
            repeat (5) @(posedge i_clk);
            $display("Covered %0d requests: %0d inserts refused when full, %0d deletes on empty,",
                     shadow.n_requests, shadow.n_refused, shadow.n_empty_deletes);
            $display("%0d no-op codes, peak occupancy %0d of %0d keys.",
                     shadow.n_nops, shadow.peak_count, CAPACITY);
            if (shadow.mismatches == 0 && shadow.pending() == 0)
                $display("double_ended_priority_queue_top test passed");
            else
                $display("double_ended_priority_queue_top test failed");
            $finish;
        end
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("double_ended_priority_queue_top test failed");
        $finish;
    end

endmodule
